// ===== design/hc27_pkg.sv =====
// shared types, constants and character mapping for the 2x2 mod-27 hill cipher core
// no dependencies; used by hc27_key_regs, hc27_mac_mod and hill_cipher_2x2_mod27_core

package hc27_pkg;

    localparam int ALPHABET_SIZE = 27;
    localparam int SYM_W         = 5;
    localparam int CHAR_W        = 8;
    localparam int KEY_COUNT     = 4;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 5;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_TL  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_TR  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_BL  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_BR  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_DECRYPT = 3'd4;

    // key reset values
    localparam logic [SYM_W-1:0] KEY_TL_RST = 5'd1;
    localparam logic [SYM_W-1:0] KEY_TR_RST = 5'd0;
    localparam logic [SYM_W-1:0] KEY_BL_RST = 5'd0;
    localparam logic [SYM_W-1:0] KEY_BR_RST = 5'd1;

    localparam logic [SYM_W-1:0] SYM_SPACE   = 5'(ALPHABET_SIZE - 1);
    localparam logic [SYM_W-1:0] SYM_MODULUS = 5'(ALPHABET_SIZE);
    localparam logic [SYM_W-1:0] SYM_ONE     = 5'd1;

    // dot product and modulo reduction widths
    localparam int SUM_W       = 11;
    localparam int RECIP       = 1214;   // ceil(2^15 / 27), exact for sums below 2048
    localparam int RECIP_SHIFT = 15;
    localparam int QUOT_W      = 6;
    localparam int PROD_W      = RECIP_SHIFT + QUOT_W;

    localparam logic [CHAR_W-1:0] CHAR_LC_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_UC_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_SP   = 8'h20;

    typedef logic [SYM_W-1:0]  t_sym;
    typedef logic [CHAR_W-1:0] t_char;

    typedef struct packed {
        t_sym a0;
        t_sym b0;
        t_sym a1;
        t_sym b1;
    } t_mac_ops;

    typedef struct packed {
        logic valid;
        logic busy;
        t_sym value;
    } t_mac_rsp;

    typedef struct packed {
        t_sym tl;
        t_sym tr;
        t_sym bl;
        t_sym br;
        t_sym neg_tr;
        t_sym neg_bl;
        logic decrypt;
        logic changed;
    } t_key_cfg;

    function automatic t_sym mod_reduce(input t_sym k);
        t_sym r;
        r = (k >= SYM_MODULUS) ? t_sym'(k - SYM_MODULUS) : k;
        return r;
    endfunction

    // additive inverse of an already reduced symbol
    function automatic t_sym mod_negate(input t_sym k);
        t_sym r;
        r = (k == '0) ? '0 : t_sym'(SYM_MODULUS - k);
        return r;
    endfunction

    function automatic t_sym char_to_symbol(input t_char c);
        t_sym s;
        if (c inside {[CHAR_LC_A:CHAR_LC_Z]}) begin
            s = t_sym'(c - CHAR_LC_A);
        end else if (c inside {[CHAR_UC_A:CHAR_UC_Z]}) begin
            s = t_sym'(c - CHAR_UC_A);
        end else if (c == CHAR_SP) begin
            s = SYM_SPACE;
        end else begin
            s = '0;
        end
        return s;
    endfunction

    function automatic t_char symbol_to_char(input t_sym s);
        t_char c;
        if (s < SYM_SPACE) begin
            c = CHAR_LC_A + t_char'(s);
        end else if (s == SYM_SPACE) begin
            c = CHAR_SP;
        end else begin
            c = '0;
        end
        return c;
    endfunction

endpackage

// ===== design/hc27_key_regs.sv =====
// key and mode registers written from the configuration port
// depends on hc27_pkg; hands reduced and negated key entries to the sequencer

module hc27_key_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [hc27_pkg::CFG_ADDR_W-1:0] i_addr,
    input  logic [hc27_pkg::CFG_DATA_W-1:0] i_wdata,
    output hc27_pkg::t_key_cfg             o_key
);

    hc27_pkg::t_sym r_key_tl;
    hc27_pkg::t_sym r_key_tr;
    hc27_pkg::t_sym r_key_bl;
    hc27_pkg::t_sym r_key_br;
    logic           r_decrypt;
    logic           addr_hit;

    always_comb begin
        case (i_addr)
            hc27_pkg::CFG_KEY_TL,
            hc27_pkg::CFG_KEY_TR,
            hc27_pkg::CFG_KEY_BL,
            hc27_pkg::CFG_KEY_BR,
            hc27_pkg::CFG_DECRYPT: addr_hit = 1'b1;
            default:               addr_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_tl  <= hc27_pkg::KEY_TL_RST;
            r_key_tr  <= hc27_pkg::KEY_TR_RST;
            r_key_bl  <= hc27_pkg::KEY_BL_RST;
            r_key_br  <= hc27_pkg::KEY_BR_RST;
            r_decrypt <= 1'b0;
        end else if (i_wr_en) begin
            case (i_addr)
                hc27_pkg::CFG_KEY_TL:  r_key_tl  <= i_wdata;
                hc27_pkg::CFG_KEY_TR:  r_key_tr  <= i_wdata;
                hc27_pkg::CFG_KEY_BL:  r_key_bl  <= i_wdata;
                hc27_pkg::CFG_KEY_BR:  r_key_br  <= i_wdata;
                hc27_pkg::CFG_DECRYPT: r_decrypt <= i_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_key.tl      = hc27_pkg::mod_reduce(r_key_tl);
        o_key.tr      = hc27_pkg::mod_reduce(r_key_tr);
        o_key.bl      = hc27_pkg::mod_reduce(r_key_bl);
        o_key.br      = hc27_pkg::mod_reduce(r_key_br);
        o_key.neg_tr  = hc27_pkg::mod_negate(o_key.tr);
        o_key.neg_bl  = hc27_pkg::mod_negate(o_key.bl);
        o_key.decrypt = r_decrypt;
        // invalidates the working matrix in the same cycle as the write
        o_key.changed = i_wr_en & addr_hit;
    end

endmodule

// ===== design/hc27_mac_mod.sv =====
// shared two-stage unit: (a0*b0 + a1*b1) mod 27
// depends on hc27_pkg; stage 1 multiplies and adds, stage 2 reduces by reciprocal

module hc27_mac_mod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req,
    input  hc27_pkg::t_mac_ops i_ops,
    output hc27_pkg::t_mac_rsp o_rsp
);

    logic [hc27_pkg::SUM_W-1:0]  r_sum;
    logic                        r_v1;
    logic                        r_v2;
    hc27_pkg::t_sym              r_value;

    logic [hc27_pkg::SUM_W-1:0]  dot_sum;
    logic [hc27_pkg::PROD_W-1:0] quot_prod;
    logic [hc27_pkg::QUOT_W-1:0] quot;
    logic [hc27_pkg::SUM_W-1:0]  rem;

    assign dot_sum = hc27_pkg::SUM_W'(i_ops.a0) * hc27_pkg::SUM_W'(i_ops.b0)
                   + hc27_pkg::SUM_W'(i_ops.a1) * hc27_pkg::SUM_W'(i_ops.b1);

    // quotient by 27 through the scaled reciprocal, then remainder
    assign quot_prod = hc27_pkg::PROD_W'(r_sum) * hc27_pkg::PROD_W'(hc27_pkg::RECIP);
    assign quot      = quot_prod[hc27_pkg::RECIP_SHIFT +: hc27_pkg::QUOT_W];
    assign rem       = r_sum - hc27_pkg::SUM_W'(quot)
                             * hc27_pkg::SUM_W'(hc27_pkg::ALPHABET_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_req;
            r_v2 <= r_v1;
        end
        r_sum   <= dot_sum;
        r_value <= hc27_pkg::t_sym'(rem);
    end

    assign o_rsp.valid = r_v2;
    assign o_rsp.busy  = r_v1 | r_v2;
    assign o_rsp.value = r_value;

endmodule

// ===== design/hill_cipher_2x2_mod27_core.sv =====
// top level of the 2x2 mod-27 hill cipher: sequencer, pair state and output stage
// depends on hc27_pkg, hc27_key_regs and hc27_mac_mod
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata[7:0] char_in
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata[7:0] char_out, tlast pair_last,
//                                                     tuser[0] key_not_invertible
//  cfg       in         i_cfg_wr_en                   i_cfg_addr register, i_cfg_wdata value
//
// the first character of a pair is stored; the second starts two dot products in turn in the
// shared multiply-mod unit, one per output row, and the two output characters then go out
// in order on m_axis
// after reset or a register write the working matrix is rebuilt before input is taken:
// in encrypt mode the key is copied; in decrypt mode the determinant, a 27-factor inverse
// search and four adjugate products go in turn through the same unit
// reset is synchronous and active low; a stall on m_axis holds the block in its output states

module hill_cipher_2x2_mod27_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] char_in
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [7:0] char_out
    output logic                            m_axis_tlast,   // pair_last
    output logic                            m_axis_tuser,   // [0] key_not_invertible
    input  logic                            i_cfg_wr_en,
    input  logic [hc27_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [hc27_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT,
        S_OUT0,
        S_OUT1
    } t_state;

    typedef enum logic [2:0] {
        ST_DET,
        ST_SEARCH,
        ST_ADJ,
        ST_ROW0,
        ST_ROW1
    } t_step;

    hc27_pkg::t_key_cfg key;
    hc27_pkg::t_mac_ops mac_ops;
    hc27_pkg::t_mac_rsp mac_rsp;
    logic               mac_req;
    logic               in_acc;
    hc27_pkg::t_sym     in_sym;
    hc27_pkg::t_sym     factor_now;
    logic               hit;

    t_state                               r_state, n_state;
    t_step                                r_step, n_step;
    logic                                 r_matrix_ready, n_matrix_ready;
    logic                                 r_inv_failed, n_inv_failed;
    logic                                 r_have_pending, n_have_pending;
    hc27_pkg::t_sym                       r_pending, n_pending;
    hc27_pkg::t_sym                       r_second, n_second;
    logic [hc27_pkg::KEY_COUNT-1:0][4:0]  r_work, n_work;
    hc27_pkg::t_sym                       r_det, n_det;
    hc27_pkg::t_sym                       r_try, n_try;
    hc27_pkg::t_sym                       r_factor, n_factor;
    logic                                 r_found, n_found;
    logic [1:0]                           r_adj, n_adj;
    hc27_pkg::t_sym                       r_out0, n_out0;
    hc27_pkg::t_sym                       r_out1, n_out1;

    hc27_key_regs u_key_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_key   (key)
    );

    hc27_mac_mod u_mac_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .i_ops   (mac_ops),
        .o_rsp   (mac_rsp)
    );

    // adjugate entries in working-matrix order
    function automatic hc27_pkg::t_sym adj_operand(input logic [1:0] idx,
                                                   input hc27_pkg::t_key_cfg k);
        hc27_pkg::t_sym r;
        case (idx)
            2'd0:    r = k.br;
            2'd1:    r = k.neg_tr;
            2'd2:    r = k.neg_bl;
            default: r = k.tl;
        endcase
        return r;
    endfunction

    assign s_axis_tready = (r_state == S_IDLE) && r_matrix_ready && !key.changed;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_sym        = hc27_pkg::char_to_symbol(s_axis_tdata);
    assign hit           = (mac_rsp.value == hc27_pkg::SYM_ONE);
    assign factor_now    = hit ? r_try : r_factor;

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        n_matrix_ready = r_matrix_ready;
        n_inv_failed   = r_inv_failed;
        n_have_pending = r_have_pending;
        n_pending      = r_pending;
        n_second       = r_second;
        n_work         = r_work;
        n_det          = r_det;
        n_try          = r_try;
        n_factor       = r_factor;
        n_found        = r_found;
        n_adj          = r_adj;
        n_out0         = r_out0;
        n_out1         = r_out1;
        mac_req        = 1'b0;
        mac_ops        = '0;

        case (r_state)
            S_IDLE: begin
                if (!r_matrix_ready) begin
                    // wait until a result left over from an aborted rebuild has drained
                    // and no key write is landing this cycle
                    if (!mac_rsp.busy && !key.changed) begin
                        if (key.decrypt) begin
                            mac_req     = 1'b1;
                            mac_ops.a0  = key.tl;
                            mac_ops.b0  = key.br;
                            mac_ops.a1  = key.neg_tr;
                            mac_ops.b1  = key.bl;
                            n_factor    = '0;
                            n_found     = 1'b0;
                            n_step      = ST_DET;
                            n_state     = S_WAIT;
                        end else begin
                            n_work[0]      = key.tl;
                            n_work[1]      = key.tr;
                            n_work[2]      = key.bl;
                            n_work[3]      = key.br;
                            n_inv_failed   = 1'b0;
                            n_matrix_ready = 1'b1;
                        end
                    end
                end else if (in_acc) begin
                    if (!r_have_pending) begin
                        n_pending      = in_sym;
                        n_have_pending = 1'b1;
                    end else begin
                        n_second   = in_sym;
                        mac_req    = 1'b1;
                        mac_ops.a0 = r_work[0];
                        mac_ops.b0 = r_pending;
                        mac_ops.a1 = r_work[1];
                        mac_ops.b1 = in_sym;
                        n_step     = ST_ROW0;
                        n_state    = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (mac_rsp.valid) begin
                    case (r_step)
                        ST_DET: begin
                            n_det      = mac_rsp.value;
                            n_try      = hc27_pkg::SYM_ONE;
                            mac_req    = 1'b1;
                            mac_ops.a0 = mac_rsp.value;
                            mac_ops.b0 = hc27_pkg::SYM_ONE;
                            n_step     = ST_SEARCH;
                        end
                        ST_SEARCH: begin
                            n_factor = factor_now;
                            n_found  = r_found | hit;
                            mac_req  = 1'b1;
                            if (r_try == hc27_pkg::SYM_MODULUS) begin
                                // factor stays zero when no inverse exists
                                mac_ops.a0 = factor_now;
                                mac_ops.b0 = adj_operand(2'd0, key);
                                n_adj      = 2'd0;
                                n_step     = ST_ADJ;
                            end else begin
                                n_try      = r_try + hc27_pkg::SYM_ONE;
                                mac_ops.a0 = r_det;
                                mac_ops.b0 = r_try + hc27_pkg::SYM_ONE;
                            end
                        end
                        ST_ADJ: begin
                            n_work[r_adj] = mac_rsp.value;
                            if (r_adj == 2'd3) begin
                                n_matrix_ready = 1'b1;
                                n_inv_failed   = !r_found;
                                n_state        = S_IDLE;
                            end else begin
                                n_adj      = r_adj + 2'd1;
                                mac_req    = 1'b1;
                                mac_ops.a0 = r_factor;
                                mac_ops.b0 = adj_operand(r_adj + 2'd1, key);
                            end
                        end
                        ST_ROW0: begin
                            n_out0     = mac_rsp.value;
                            mac_req    = 1'b1;
                            mac_ops.a0 = r_work[2];
                            mac_ops.b0 = r_pending;
                            mac_ops.a1 = r_work[3];
                            mac_ops.b1 = r_second;
                            n_step     = ST_ROW1;
                        end
                        ST_ROW1: begin
                            n_out1         = mac_rsp.value;
                            n_have_pending = 1'b0;
                            n_pending      = '0;
                            n_state        = S_OUT0;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_OUT0: begin
                if (m_axis_tready) begin
                    n_state = S_OUT1;
                end
            end
            S_OUT1: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // a key write restarts any rebuild in progress
        if (key.changed) begin
            n_matrix_ready = 1'b0;
            if (r_state == S_WAIT &&
                (r_step == ST_DET || r_step == ST_SEARCH || r_step == ST_ADJ)) begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_step         <= ST_DET;
            r_matrix_ready <= 1'b0;
            r_inv_failed   <= 1'b0;
            r_have_pending <= 1'b0;
            r_pending      <= '0;
        end else begin
            r_state        <= n_state;
            r_step         <= n_step;
            r_matrix_ready <= n_matrix_ready;
            r_inv_failed   <= n_inv_failed;
            r_have_pending <= n_have_pending;
            r_pending      <= n_pending;
        end
        r_second <= n_second;
        r_work   <= n_work;
        r_det    <= n_det;
        r_try    <= n_try;
        r_factor <= n_factor;
        r_found  <= n_found;
        r_adj    <= n_adj;
        r_out0   <= n_out0;
        r_out1   <= n_out1;
    end

    assign m_axis_tvalid = (r_state == S_OUT0) || (r_state == S_OUT1);
    assign m_axis_tlast  = (r_state == S_OUT1);
    assign m_axis_tdata  = hc27_pkg::symbol_to_char((r_state == S_OUT1) ? r_out1 : r_out0);
    assign m_axis_tuser  = r_inv_failed;

    // the unit is drained whenever new input can be taken
    a_ready_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !mac_rsp.busy)
        else $error("input taken while the shared unit still holds work");

    // a unit result only shows up while it is awaited or after an aborted rebuild
    a_rsp_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_rsp.valid |-> (r_state == S_WAIT) || (r_state == S_IDLE && !r_matrix_ready))
        else $error("unexpected result from the shared unit");

    // the second character of a pair starts the row products
    a_pair_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_have_pending) |=> (r_state == S_WAIT && r_step == ST_ROW0))
        else $error("second character of a pair did not start the multiply");

    // the first character of a pair is always followed by the last one
    a_pair_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("output pair broken");

endmodule

// ===== tb/tb_hill_cipher_2x2_mod27_core.sv =====
// self-checking bench for hill_cipher_2x2_mod27_core: character stream in, cipher pairs out
// predicts every output character from its own key registers; needs hc27_pkg and the core
`timescale 1ns / 100ps

module tb_hill_cipher_2x2_mod27_core;
    import hc27_pkg::*;

    localparam int MOD           = 27;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 150;
    localparam int STALL_LIMIT   = 5000;
    localparam int REPORT_MAX    = 10;

    // register indexes past the decrypt flag are not mapped
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED_LO = CFG_DECRYPT + 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_FF     = 8'hFF;
    localparam logic [7:0] CHAR_AT     = 8'h40;
    localparam logic [7:0] CHAR_LBRACK = 8'h5B;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       bad_key;
    } cipher_out_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic m_axis_tlast;
    logic m_axis_tuser;
    logic i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    hill_cipher_2x2_mod27_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // bench copy of the key registers and pair state
    logic [4:0] key_reg [4];
    logic       decrypt_on;
    int         half_sym;
    bit         half_valid;
    int         work_mat [4];
    bit         key_singular;

    logic [7:0]  chars_to_send [$];
    cipher_out_t cipher_expected [$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_req_id = 0;
    int mismatches = 0;
    int chars_sent = 0;
    int chars_checked = 0;
    int decrypt_checked = 0;
    int flagged_checked = 0;
    int key_settings = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int map_char(input logic [7:0] c);
        if (c >= CHAR_LC_A && c <= CHAR_LC_Z) return int'(c - CHAR_LC_A);
        if (c >= CHAR_UC_A && c <= CHAR_UC_Z) return int'(c - CHAR_UC_A);
        if (c == CHAR_SP) return MOD - 1;
        return 0;
    endfunction

    function automatic logic [7:0] sym_char(input int s);
        if (s < MOD - 1) return CHAR_LC_A + 8'(s);
        return CHAR_SP;
    endfunction

    // working matrix from the current key: the key itself, or factor times adjugate
    function automatic void build_work_matrix();
        int k [4];
        int det;
        int factor;
        for (int i = 0; i < 4; i++) k[i] = int'(key_reg[i]) % MOD;
        key_singular = 1'b0;
        if (!decrypt_on) begin
            for (int i = 0; i < 4; i++) work_mat[i] = k[i];
        end else begin
            det = (k[0] * k[3] - k[1] * k[2]) % MOD;
            if (det < 0) det += MOD;
            factor = 0;
            for (int f = 1; f <= MOD; f++) begin
                if ((det * f) % MOD == 1) factor = f;
            end
            key_singular = (factor == 0);
            work_mat[0] = (factor * k[3]) % MOD;
            work_mat[1] = (factor * ((MOD - k[1]) % MOD)) % MOD;
            work_mat[2] = (factor * ((MOD - k[2]) % MOD)) % MOD;
            work_mat[3] = (factor * k[0]) % MOD;
        end
    endfunction

    function automatic void predict_cipher(input logic [7:0] c);
        int s;
        int r0;
        int r1;
        cipher_out_t o;
        s = map_char(c);
        if (!half_valid) begin
            half_sym = s;
            half_valid = 1'b1;
            return;
        end
        build_work_matrix();
        r0 = (work_mat[0] * half_sym + work_mat[1] * s) % MOD;
        r1 = (work_mat[2] * half_sym + work_mat[3] * s) % MOD;
        half_valid = 1'b0;
        half_sym = 0;
        o.bad_key = decrypt_on && key_singular;
        o.ch = sym_char(r0);
        o.last = 1'b0;
        cipher_expected.push_back(o);
        o.ch = sym_char(r1);
        o.last = 1'b1;
        cipher_expected.push_back(o);
    endfunction

    // driver: offers queued characters, predicts on every accepted request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_cipher(s_axis_tdata);
                chars_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (chars_to_send.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= chars_to_send.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each output character, drives tready with random and long stalls
    int hold_seen_id = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        cipher_out_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                chars_checked++;
                if (cipher_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected output char %h last %b flag %b",
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end else begin
                    want = cipher_expected.pop_front();
                    if (want.bad_key) flagged_checked++;
                    if (decrypt_on) decrypt_checked++;
                    if (m_axis_tdata !== want.ch || m_axis_tlast !== want.last ||
                        m_axis_tuser !== want.bad_key) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("output %0d: expected char %h last %b flag %b, got %h %b %b",
                                     chars_checked, want.ch, want.last, want.bad_key,
                                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    end
                end
            end
            if (hold_req_id != hold_seen_id) begin
                hold_seen_id = hold_req_id;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
            $display("hill_cipher_2x2_mod27_core: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_KEY_TL:  key_reg[0] = val;
            CFG_KEY_TR:  key_reg[1] = val;
            CFG_KEY_BL:  key_reg[2] = val;
            CFG_KEY_BR:  key_reg[3] = val;
            CFG_DECRYPT: decrypt_on = val[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_key(input logic [4:0] tl, tr, bl, br, input logic dec);
        write_reg(CFG_KEY_TL, tl);
        write_reg(CFG_KEY_TR, tr);
        write_reg(CFG_KEY_BL, bl);
        write_reg(CFG_KEY_BR, br);
        write_reg(CFG_DECRYPT, CFG_DATA_W'(dec));
        key_settings++;
    endtask

    // wait until every request is out and every output char is in, then let the core settle
    task automatic drain(input int settle);
        @(negedge i_clk);
        while (chars_to_send.size() > 0 || s_axis_tvalid || cipher_expected.size() > 0)
            @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic queue_chars(input logic [7:0] c0, input logic [7:0] c1);
        @(negedge i_clk);
        chars_to_send.push_back(c0);
        chars_to_send.push_back(c1);
    endtask

    function automatic logic [7:0] random_char();
        int r;
        r = $urandom_range(99);
        if (r < 30) return CHAR_LC_A + 8'($urandom_range(25));
        if (r < 55) return CHAR_UC_A + 8'($urandom_range(25));
        if (r < 68) return CHAR_SP;
        return 8'($urandom_range(255));
    endfunction

    initial begin
        int n;
        logic [4:0] kv [4];
        key_reg[0] = KEY_TL_RST;
        key_reg[1] = KEY_TR_RST;
        key_reg[2] = KEY_BL_RST;
        key_reg[3] = KEY_BR_RST;
        decrypt_on = 1'b0;
        half_sym = 0;
        half_valid = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset key is the identity: plain mapping of letters, space and other bytes
        queue_chars("a", "z");
        queue_chars("A", "Z");
        queue_chars(CHAR_SP, CHAR_AT);
        queue_chars(CHAR_NUL, CHAR_FF);
        queue_chars(CHAR_LBRACK, CHAR_LBRACE);
        drain(20);
        set_key(5'd2, 5'd3, 5'd1, 5'd4, 1'b0);
        queue_chars("h", "i");
        drain(20);
        write_reg(CFG_DECRYPT, 5'd1);
        queue_chars("Z", CHAR_SP);
        drain(20);
        // singular key in decrypt mode, every output flagged
        set_key(5'd1, 5'd2, 5'd2, 5'd4, 1'b1);
        queue_chars("q", "w");
        drain(20);
        // entries above the modulus; odd char left pending across ignored writes
        set_key(5'd31, 5'd29, 5'd28, 5'd27, 1'b1);
        queue_chars("k", "e");
        @(negedge i_clk);
        chars_to_send.push_back("y");
        drain(20);
        write_reg(CFG_UNMAPPED_LO, 5'd31);
        write_reg(CFG_UNMAPPED_HI, 5'd0);
        @(negedge i_clk);
        chars_to_send.push_back(CHAR_SP);
        drain(20);

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 82 : 0;
            sink_stall_pct = (phase == 0) ? 82 : (phase == 1) ? 32 : 0;
            for (int seg = 0; seg < 5; seg++) begin
                for (int i = 0; i < 4; i++) begin
                    case (seg)
                        0: kv[i] = (phase == 1) ? 5'd26 : 5'd0;
                        1: kv[i] = 5'd31;
                        default: kv[i] = 5'($urandom_range(31));
                    endcase
                end
                set_key(kv[0], kv[1], kv[2], kv[3], 1'($urandom_range(1)));
                n = $urandom_range(30, 36);
                @(negedge i_clk);
                if (phase == 2 && seg == 2) hold_req_id++;
                for (int i = 0; i < n; i++) begin
                    chars_to_send.push_back(random_char());
                    // mid-segment pause with everything drained
                    if (seg == 3 && i == n / 2) drain(0);
                end
                drain(20);
            end
        end

        drain(SETTLE_CYCLES);
        $display("sent %0d chars over %0d key settings, checked %0d output chars",
                 chars_sent, key_settings, chars_checked);
        $display("%0d outputs in decrypt mode, %0d flagged as singular key, %0d mismatches",
                 decrypt_checked, flagged_checked, mismatches);
        if (mismatches == 0 && cipher_expected.size() == 0) begin
            $display("hill_cipher_2x2_mod27_core: match");
        end else begin
            $display("hill_cipher_2x2_mod27_core: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/hc27_pkg.sv
design/hc27_key_regs.sv
design/hc27_mac_mod.sv
design/hill_cipher_2x2_mod27_core.sv
tb/tb_hill_cipher_2x2_mod27_core.sv
